FILE: hw/rtl/multi_frame_temporal_smoother_defines.svh
// ----------------------------------------------------------------------------
// multi_frame_temporal_smoother_defines
// Assertion macros shared by the smoother RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_FRAME_TEMPORAL_SMOOTHER_DEFINES_SVH
`define MULTI_FRAME_TEMPORAL_SMOOTHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check prop on every edge outside reset
`define MFTS_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mfts assertion failed");
// check that cond never holds outside reset
`define MFTS_ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("mfts forbidden condition");
`else
`define MFTS_ASSERT(name, prop)
`define MFTS_ASSERT_NEVER(name, cond)
`endif

`endif

FILE: hw/rtl/mfts_pkg.sv
// ----------------------------------------------------------------------------
// mfts_pkg
// Types, register indexes and fixed-point helpers of the temporal smoother.
// ----------------------------------------------------------------------------
package mfts_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 16;

	localparam logic [1:0] REG_ALPHA  = 2'd0;
	localparam logic [1:0] REG_ENABLE = 2'd1;
	localparam logic [1:0] REG_GAIN   = 2'd2;

	localparam logic [15:0] ALPHA_RST = 16'd9830;
	localparam logic [15:0] GAIN_RST  = 16'd16384;
	localparam logic [15:0] ALPHA_ONE = 16'd32768;

	// 0.8^(k+1) in Q15
	localparam logic [14:0] DECAY_Q15 [8] = '{
		15'd26214, 15'd20972, 15'd16777, 15'd13422,
		15'd10737, 15'd8590,  15'd6872,  15'd5498
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_GAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic gain;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic smooth_go;
		logic more;
		logic out_free;
	} status_t;

	// w = (min(alpha, 1.0) * decay[idx] + 0.5) in Q15
	function automatic logic [15:0] blend_weight(input logic [15:0] alpha,
		input logic [2:0] idx);
		logic [15:0] a;
		logic [31:0] p;
		a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
		p = 32'(a) * 32'(DECAY_Q15[idx]) + 32'd16384;
		return p[30:15];
	endfunction

endpackage

FILE: hw/rtl/mfts_ram.sv
// ----------------------------------------------------------------------------
// mfts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2400,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/mfts_ctrl.sv
// ----------------------------------------------------------------------------
// mfts_ctrl
// Sequencer: accept a word, step the blend over stored frames, apply gain,
// hand the result to the output register.
// ----------------------------------------------------------------------------
module mfts_ctrl import mfts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.smooth_go ? ST_READ : ST_GAIN;
				end
			end
			ST_READ: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.more ? ST_MUL : ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/mfts_dp.sv
// ----------------------------------------------------------------------------
// mfts_dp
// Datapath: configuration registers, frame bookkeeping, history RAM,
// blend accumulator, gain multiply, saturation and output register.
// ----------------------------------------------------------------------------
module mfts_dp import mfts_pkg::*; #(
	parameter int FRAME_LEN      = 480,
	parameter int HISTORY_FRAMES = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    status,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic                       frame_last
);

	localparam int DEPTH = FRAME_LEN * HISTORY_FRAMES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam int SW    = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
	localparam int CW    = $clog2(HISTORY_FRAMES + 1);
	localparam logic [AW-1:0] FL_A      = AW'(FRAME_LEN);
	localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_LEN - 1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_FRAMES - 1);
	localparam logic [CW-1:0] FRAMES    = CW'(HISTORY_FRAMES);

	logic [15:0] alpha_q;
	logic        enable_q;
	logic [15:0] gain_q;

	logic [PW-1:0] pos_q;
	logic [SW-1:0] newest_q;
	logic [CW-1:0] stored_q;
	logic [CW-1:0] k_q;
	logic [SW-1:0] rd_slot_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [31:0]         s_q;
	logic [15:0]                w_q;
	logic signed [49:0]         prod_s1;
	logic signed [48:0]         gprod_s2;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       frame_last_q;

	logic [SW-1:0]       wslot;
	logic [SW-1:0]       rd_slot_dec;
	logic [CW-1:0]       k_inc;
	logic                last_pos;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic                ram_we;
	logic [SAMPLE_W-1:0] rdata;
	logic signed [SAMPLE_W-1:0] h;
	logic signed [32:0]  diff;
	logic signed [16:0]  w_s;
	logic signed [16:0]  g_s;
	logic signed [49:0]  rnd;
	logic signed [48:0]  ybias;
	logic signed [48:0]  yq;
	logic signed [SAMPLE_W-1:0] ysat;
	logic                out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RST;
			enable_q <= 1'b1;
			gain_q   <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA:  alpha_q  <= cfg_data;
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_GAIN:   gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wslot       = (newest_q == SLOT_LAST) ? '0 : newest_q + 1'b1;
	assign rd_slot_dec = (rd_slot_q == '0) ? SLOT_LAST : rd_slot_q - 1'b1;
	assign k_inc       = k_q + 1'b1;
	assign last_pos    = (pos_q == POS_LAST);

	assign raddr  = AW'(rd_slot_q) * FL_A + AW'(pos_q);
	assign waddr  = AW'(wslot) * FL_A + AW'(pos_q);
	assign ram_we = cmd.gain & enable_q;

	mfts_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(x_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign h    = signed'(rdata);
	assign diff = signed'({h[15], h, 15'b0}) - signed'({s_q[31], s_q});
	assign w_s  = signed'({1'b0, w_q});
	assign g_s  = signed'({1'b0, gain_q});
	assign rnd  = (prod_s1 + 50'sd16384) >>> 15;

	// truncate toward zero: bias negative products before the shift
	assign ybias = gprod_s2 + (gprod_s2[48] ? 49'sd536870911 : 49'sd0);
	assign yq    = ybias >>> 29;
	always_comb begin
		if (yq > 49'sd32767) begin
			ysat = 16'sh7fff;
		end else if (yq < -49'sd32768) begin
			ysat = -16'sh8000;
		end else begin
			ysat = yq[15:0];
		end
	end

	// blend and gain
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q       <= sample;
			s_q       <= signed'({sample[15], sample, 15'b0});
			w_q       <= blend_weight(alpha_q, 3'd0);
		end
		if (cmd.mul) begin
			prod_s1 <= diff * w_s;
			w_q     <= blend_weight(alpha_q, 3'(k_inc));
		end
		if (cmd.acc) begin
			s_q <= s_q + signed'(rnd[31:0]);
		end
		if (cmd.gain) begin
			gprod_s2 <= s_q * g_s;
		end
	end

	// history walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			rd_slot_q <= '0;
		end else if (cmd.load) begin
			k_q       <= '0;
			rd_slot_q <= newest_q;
		end else if (cmd.mul) begin
			k_q       <= k_inc;
			rd_slot_q <= rd_slot_dec;
		end
	end

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			newest_q <= '0;
			stored_q <= '0;
		end else if (cmd.emit) begin
			if (last_pos) begin
				pos_q <= '0;
				if (enable_q) begin
					newest_q <= wslot;
					if (stored_q != FRAMES) begin
						stored_q <= stored_q + 1'b1;
					end
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sample_q <= ysat;
			frame_last_q <= last_pos;
		end
	end

	assign status.smooth_go = enable_q && (stored_q != '0);
	assign status.more      = (k_q < stored_q);
	assign status.out_free  = out_free;

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign frame_last = frame_last_q;

endmodule

FILE: hw/rtl/multi_frame_temporal_smoother.sv
// ----------------------------------------------------------------------------
// multi_frame_temporal_smoother
// Audio post-filter: blends each sample with the same position of up to
// HISTORY_FRAMES earlier frames, then applies output gain and saturation.
//
// Input channel: sample with in_valid / in_stall. A word is taken while
// in_stall is low; in_stall stays high while a word is in work.
// Output channel: out_sample and frame_last with out_valid / out_stall,
// held in an output register, so the next input word is taken while a
// finished result still waits for the receiver.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
// alpha, enable or gain; write only while no word is in work.
// Sequence: a word passes idle, read, a multiply and accumulate pair per
// stored frame in use, gain and emit; with smoothing off or no history it
// passes idle, gain and emit. Each stored frame takes one multiply step and
// one accumulate step of the shared blend loop; the history RAM read is
// registered, so the read state fetches the first frame ahead of the multiply.
// Reset clears frame position, history count and configuration to defaults;
// history RAM content is not cleared. A stalled receiver holds the result
// in the output register and the block waits before loading the next one.
// ----------------------------------------------------------------------------
`include "multi_frame_temporal_smoother_defines.svh"

module multi_frame_temporal_smoother import mfts_pkg::*; #(
	parameter int FRAME_LEN      = 480,
	parameter int HISTORY_FRAMES = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic                       frame_last
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	mfts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	mfts_dp #(
		.FRAME_LEN     (FRAME_LEN),
		.HISTORY_FRAMES(HISTORY_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_sample(out_sample),
		.frame_last(frame_last)
	);

	`MFTS_ASSERT(a_accept_then_busy, (in_valid && !in_stall) |=> in_stall)
	`MFTS_ASSERT(a_one_cmd, $onehot0(cmd))
	`MFTS_ASSERT_NEVER(a_emit_overwrites, cmd.emit && out_valid && out_stall)
	`MFTS_ASSERT(a_emit_shows, cmd.emit |=> out_valid)

endmodule
